/* src/fddg_pkg.sv */
// -----------------------------------------------------------------------------
// fddg_pkg
// Shared widths, constants and controller/datapath interface types for the
// fraction decimal digit generator.
// -----------------------------------------------------------------------------
package fddg_pkg;

    // Field widths
    localparam int NUM_W   = 31;          // numerator / denominator
    localparam int DIGIT_W = 4;           // one decimal digit, 0..10
    localparam int T_W     = NUM_W + 4;   // ten times a remainder
    localparam int IDX_W   = 2;           // quotient bit index, 3 down to 0

    // Default digit count per transaction
    localparam int DIGITS_DEF = 21;

    // Highest quotient bit of one digit step (quotient never exceeds ten)
    localparam logic [IDX_W-1:0] IDX_TOP = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic             load;      // capture the input pair
        logic             mul;       // multiply remainder by ten, clear quotient
        logic             step;      // one restoring divide step
        logic [IDX_W-1:0] idx;       // quotient bit for this step
        logic             out_load;  // load the result register
        logic             out_err;   // result is an error result
        logic             out_last;  // result closes the run
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic bad;                   // zero denominator or numerator above it
    } t_sts;

endpackage

/* src/fddg_datapath.sv */
// -----------------------------------------------------------------------------
// fddg_datapath
// Running remainder, denominator, quotient build-up and result register.
// One quotient bit is resolved per step by compare and subtract.
// -----------------------------------------------------------------------------
module fddg_datapath
    import fddg_pkg::*;
(
    input  logic               i_clk,
    input  logic [NUM_W-1:0]   i_numerator,
    input  logic [NUM_W-1:0]   i_denominator,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    output logic [DIGIT_W-1:0] o_digit,
    output logic               o_error,
    output logic               o_last
);

    logic [T_W-1:0]     r_t;
    logic [T_W-1:0]     n_t;
    logic [NUM_W-1:0]   r_den;
    logic [DIGIT_W-1:0] r_q;
    logic [DIGIT_W-1:0] n_q;
    logic [DIGIT_W-1:0] r_digit;
    logic               r_error;
    logic               r_last;

    logic [T_W-1:0]     ten_r;
    logic [T_W-1:0]     den_sh;
    logic               fits;

    // Ten times the remainder as eight times plus two times
    assign ten_r = T_W'({r_t[NUM_W-1:0], 3'b000}) + T_W'({r_t[NUM_W-1:0], 1'b0});

    // Shifted divisor and trial compare for the current quotient bit
    assign den_sh = T_W'(r_den) << i_cmd.idx;
    assign fits   = (r_t >= den_sh);

    // Select next remainder and quotient
    always_comb begin
        n_t = r_t;
        n_q = r_q;
        if (i_cmd.load) begin
            n_t = T_W'(i_numerator);
        end else if (i_cmd.mul) begin
            n_t = ten_r;
            n_q = '0;
        end else if (i_cmd.step && fits) begin
            n_t = r_t - den_sh;
            n_q = r_q | (DIGIT_W'(1) << i_cmd.idx);
        end
    end

    // Hold working registers
    always_ff @(posedge i_clk) begin
        r_t <= n_t;
        r_q <= n_q;
        if (i_cmd.load) begin
            r_den <= i_denominator;
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_digit <= i_cmd.out_err ? '0 : r_q;
            r_error <= i_cmd.out_err;
            r_last  <= i_cmd.out_last;
        end
    end

    // Reject a zero denominator or a numerator above the denominator
    assign o_sts.bad = (r_den == '0) || (r_t[NUM_W-1:0] > r_den);

    assign o_digit = r_digit;
    assign o_error = r_error;
    assign o_last  = r_last;

endmodule

/* src/fddg_ctrl.sv */
// -----------------------------------------------------------------------------
// fddg_ctrl
// Sequencer for one transaction: check, then per digit a multiply state,
// four divide steps and an emit state. Owns the output valid flag.
// -----------------------------------------------------------------------------
module fddg_ctrl
    import fddg_pkg::*;
#(
    parameter int DIGITS = DIGITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  logic i_stall,
    output logic o_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam int CNT_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_ERR,
        S_MUL,
        S_DIV,
        S_EMIT
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic             r_valid;
    logic             n_valid;

    logic             out_free;
    logic             cnt_end;

    assign out_free = !r_valid || !i_stall;
    assign cnt_end  = (r_cnt == CNT_W'(DIGITS - 1));

    // Decode commands and next state
    always_comb begin
        n_state         = r_state;
        n_cnt           = r_cnt;
        n_idx           = r_idx;
        n_valid         = r_valid && i_stall;
        o_cmd           = '0;
        o_cmd.idx       = r_idx;
        o_cmd.out_last  = cnt_end;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHK;
                end
            end
            S_CHK: begin
                n_cnt   = '0;
                n_state = i_sts.bad ? S_ERR : S_MUL;
            end
            S_ERR: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_err  = 1'b1;
                    o_cmd.out_last = 1'b1;
                    n_valid        = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_idx     = IDX_TOP;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                n_idx      = r_idx - 1'b1;
                if (r_idx == '0) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_valid        = 1'b1;
                    n_cnt          = r_cnt + 1'b1;
                    n_state        = cnt_end ? S_IDLE : S_MUL;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state, counters and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

/* src/fraction_decimal_digit_generator_top.sv */
// -----------------------------------------------------------------------------
// fraction_decimal_digit_generator_top
// Decimal expansion of a proper fraction by long division, one digit at a time.
//
//   channel  direction  handshake           payload
//   input    in         i_valid / o_stall   i_numerator, i_denominator
//   result   out        o_valid / i_stall   o_digit, o_error, o_last
//
// A transaction runs a load and a check step and then, per digit, a
// multiply-by-ten step, four compare-and-subtract steps of the shared
// divide unit and an emit step.
// A rejected pair gives one error result.
// Reset is synchronous and active low; it clears the sequencer and output valid.
// A stalled result holds the sequencer in its emit cycle; a new transaction
// is taken while the final result still waits.
// -----------------------------------------------------------------------------
module fraction_decimal_digit_generator_top
    import fddg_pkg::*;
#(
    parameter int DIGITS = DIGITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [NUM_W-1:0]   i_numerator,
    input  logic [NUM_W-1:0]   i_denominator,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [DIGIT_W-1:0] o_digit,
    output logic               o_error,
    output logic               o_last
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    fddg_ctrl #(
        .DIGITS (DIGITS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Divide datapath and result register
    fddg_datapath u_datapath (
        .i_clk         (i_clk),
        .i_numerator   (i_numerator),
        .i_denominator (i_denominator),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_digit       (o_digit),
        .o_error       (o_error),
        .o_last        (o_last)
    );

endmodule
